@@ src/lbp_pkg.sv @@
// ----------------------------------------------------------------------------
// LED blink pattern player package
// Shared sizes, command and register codes, controller-to-datapath command
// and status types, and small arithmetic helpers.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int PATTERN_DEPTH  = 64;
   localparam int DURATION_BITS  = 16;

   localparam int DUR_FIELD_BITS = 16;
   localparam int CNT_BITS       = 8;
   localparam int CMD_BITS       = 3;
   localparam int DIV_BITS       = 16;
   localparam int PLEN_BITS      = 7;
   localparam int DIGIT_BITS     = 4;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam int ADDR_BITS  = $clog2(PATTERN_DEPTH);
   localparam int LEN_BITS   = $clog2(PATTERN_DEPTH + 1);
   localparam int STEP_BITS  = (LEN_BITS > CNT_BITS + 1) ? LEN_BITS : CNT_BITS + 1;
   localparam int WIDE_BITS  =
      ((DURATION_BITS > DUR_FIELD_BITS) ? DURATION_BITS : DUR_FIELD_BITS) + 1;
   localparam int CD_BITS    = WIDE_BITS + DIV_BITS;

   localparam logic [WIDE_BITS-1:0] DUR_MAX =
      (WIDE_BITS'(1) << DURATION_BITS) - WIDE_BITS'(1);

   localparam logic [WIDE_BITS-1:0]  INTERJECT_TAIL = WIDE_BITS'(100);
   localparam logic [DUR_FIELD_BITS-1:0] DIGIT_FIRST_ON = DUR_FIELD_BITS'(2);
   localparam logic [DUR_FIELD_BITS-1:0] DIGIT_UNIT     = DUR_FIELD_BITS'(1);
   localparam logic [DUR_FIELD_BITS-1:0] DIGIT_TAIL_OFF = DUR_FIELD_BITS'(4);
   localparam logic [DIGIT_BITS-1:0]     DIGIT_ZERO_BLINKS = DIGIT_BITS'(10);

   // Division by five of a 16-bit value: multiply by ceil(2^18 / 5), shift by 18.
   localparam logic [DIV_BITS-1:0] DIV5_MAGIC = 16'hCCCD;
   localparam int                  DIV5_SHIFT = 18;
   // Division by ten of an 8-bit value: multiply by 205, shift by 11.
   localparam logic [CNT_BITS-1:0] DIV10_MAGIC = 8'd205;
   localparam int                  DIV10_SHIFT = 11;
   localparam logic [CNT_BITS-1:0] TEN = 8'd10;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK      = 3'd0,
      CMD_CLEAR     = 3'd1,
      CMD_ADD_ON    = 3'd2,
      CMD_ADD_OFF   = 3'd3,
      CMD_ADD_DIGIT = 3'd4,
      CMD_INTERJECT = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      REG_TICK_DIVIDER = 2'd0,
      REG_INVERT_LEVEL = 2'd1,
      REG_LED_ENABLE   = 2'd2
   } reg_idx_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_INTERJECT,
      OP_APP_READ,
      OP_APP_WRITE,
      OP_TICK_CHECK,
      OP_TICK_WRAP,
      OP_TICK_READ,
      OP_TICK_LOAD,
      OP_CAPTURE
   } dp_op_type;

   typedef enum logic [1:0] {
      VAL_DURATION,
      VAL_DIGIT_ON,
      VAL_UNIT,
      VAL_TAIL
   } app_val_type;

   typedef struct packed {
      dp_op_type   op;
      logic        accept;
      logic        app_on;
      app_val_type app_val;
      logic        digit_next;
   } dp_cmd_type;

   typedef struct packed {
      logic tick_active;
      logic cd_zero;
      logic cd_one;
      logic wrap_done;
      logic digit_last;
      logic rsp_free;
   } dp_status_type;

   typedef struct packed {
      logic [DIV_BITS-1:0] tick_divider;
      logic                invert_level;
      logic                led_enable;
   } cfg_type;

   function automatic logic [DURATION_BITS-1:0] clamp_duration(
      input logic [WIDE_BITS-1:0] v
   );
      if (v > DUR_MAX) begin
         return DUR_MAX[DURATION_BITS-1:0];
      end
      return v[DURATION_BITS-1:0];
   endfunction

   function automatic logic [DIV_BITS-1:0] div_by_five(input logic [DIV_BITS-1:0] v);
      logic [2*DIV_BITS-1:0] p;
      p = v * DIV5_MAGIC;
      return DIV_BITS'(p >> DIV5_SHIFT);
   endfunction

   function automatic logic [DIGIT_BITS-1:0] digit_blinks(input logic [CNT_BITS-1:0] v);
      logic [2*CNT_BITS-1:0] p;
      logic [CNT_BITS-1:0]   q;
      logic [CNT_BITS-1:0]   r;
      p = v * DIV10_MAGIC;
      q = CNT_BITS'(p >> DIV10_SHIFT);
      r = v - CNT_BITS'(q * TEN);
      if (r == '0) begin
         return DIGIT_ZERO_BLINKS;
      end
      return r[DIGIT_BITS-1:0];
   endfunction

endpackage

@@ src/lbp_csr.sv @@
// ----------------------------------------------------------------------------
// LED blink pattern player register port
// Holds the divider, polarity and enable registers behind a simple APB port.
// ----------------------------------------------------------------------------
module lbp_csr import lbp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   logic [DIV_BITS-1:0] div_ff, div_in;
   logic                inv_ff, inv_in;
   logic                en_ff, en_in;
   logic                wr_en;
   reg_idx_type         idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = reg_idx_type'(csr_paddr[3:2]);

   always_comb begin
      div_in = div_ff;
      inv_in = inv_ff;
      en_in  = en_ff;
      if (wr_en) begin
         unique case (idx)
            REG_TICK_DIVIDER: div_in = csr_pwdata[DIV_BITS-1:0];
            REG_INVERT_LEVEL: inv_in = csr_pwdata[0];
            REG_LED_ENABLE:   en_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_TICK_DIVIDER: csr_prdata = CSR_DATA_BITS'(div_ff);
         REG_INVERT_LEVEL: csr_prdata = CSR_DATA_BITS'(inv_ff);
         REG_LED_ENABLE:   csr_prdata = CSR_DATA_BITS'(en_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= DIV_BITS'(1);
         inv_ff <= 1'b0;
         en_ff  <= 1'b1;
      end else begin
         div_ff <= div_in;
         inv_ff <= inv_in;
         en_ff  <= en_in;
      end
   end

   assign cfg.tick_divider = div_ff;
   assign cfg.invert_level = inv_ff;
   assign cfg.led_enable   = en_ff;

endmodule

@@ src/lbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// LED blink pattern player controller
// Sequences each command word through the datapath: table appends as a read
// and a write, digits as a series of appends, ticks as check, wrap, read and
// load steps, then hands the result to the output register.
// ----------------------------------------------------------------------------
module lbp_ctrl import lbp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  cmd_type       req_cmd,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_CLEAR     = 10'b00_0000_0010,
      ST_INTERJ    = 10'b00_0000_0100,
      ST_APP_RD    = 10'b00_0000_1000,
      ST_APP_WR    = 10'b00_0001_0000,
      ST_TICK_CHK  = 10'b00_0010_0000,
      ST_TICK_WRAP = 10'b00_0100_0000,
      ST_TICK_RD   = 10'b00_1000_0000,
      ST_TICK_LOAD = 10'b01_0000_0000,
      ST_FINISH    = 10'b10_0000_0000
   } state_type;

   typedef enum logic [4:0] {
      PH_SINGLE_ON  = 5'b00001,
      PH_SINGLE_OFF = 5'b00010,
      PH_DIG_ON     = 5'b00100,
      PH_DIG_OFF    = 5'b01000,
      PH_TAIL       = 5'b10000
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in          = state_ff;
      phase_in          = phase_ff;
      dp_cmd.op         = OP_NONE;
      dp_cmd.accept     = 1'b0;
      dp_cmd.app_on     = 1'b0;
      dp_cmd.app_val    = VAL_DURATION;
      dp_cmd.digit_next = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.accept = 1'b1;
               unique case (req_cmd)
                  CMD_TICK:      state_in = ST_TICK_CHK;
                  CMD_CLEAR:     state_in = ST_CLEAR;
                  CMD_INTERJECT: state_in = ST_INTERJ;
                  CMD_ADD_ON: begin
                     phase_in = PH_SINGLE_ON;
                     state_in = ST_APP_RD;
                  end
                  CMD_ADD_OFF: begin
                     phase_in = PH_SINGLE_OFF;
                     state_in = ST_APP_RD;
                  end
                  CMD_ADD_DIGIT: begin
                     phase_in = PH_DIG_ON;
                     state_in = ST_APP_RD;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_CLEAR: begin
            dp_cmd.op = OP_CLEAR;
            state_in  = ST_FINISH;
         end
         ST_INTERJ: begin
            dp_cmd.op = OP_INTERJECT;
            state_in  = ST_FINISH;
         end
         ST_APP_RD: begin
            dp_cmd.op = OP_APP_READ;
            state_in  = ST_APP_WR;
         end
         ST_APP_WR: begin
            dp_cmd.op = OP_APP_WRITE;
            unique case (phase_ff)
               PH_SINGLE_ON: begin
                  dp_cmd.app_on = 1'b1;
                  state_in      = ST_FINISH;
               end
               PH_SINGLE_OFF: begin
                  state_in = ST_FINISH;
               end
               PH_DIG_ON: begin
                  dp_cmd.app_on  = 1'b1;
                  dp_cmd.app_val = VAL_DIGIT_ON;
                  phase_in       = PH_DIG_OFF;
                  state_in       = ST_APP_RD;
               end
               PH_DIG_OFF: begin
                  dp_cmd.app_val    = VAL_UNIT;
                  dp_cmd.digit_next = 1'b1;
                  phase_in          = status.digit_last ? PH_TAIL : PH_DIG_ON;
                  state_in          = ST_APP_RD;
               end
               PH_TAIL: begin
                  dp_cmd.app_val = VAL_TAIL;
                  state_in       = ST_FINISH;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_TICK_CHK: begin
            dp_cmd.op = OP_TICK_CHECK;
            priority if (!status.tick_active) begin
               state_in = ST_FINISH;
            end else if (status.cd_zero) begin
               state_in = ST_TICK_RD;
            end else if (status.cd_one) begin
               state_in = ST_TICK_WRAP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_TICK_WRAP: begin
            dp_cmd.op = OP_TICK_WRAP;
            if (status.wrap_done) begin
               state_in = ST_TICK_RD;
            end
         end
         ST_TICK_RD: begin
            dp_cmd.op = OP_TICK_READ;
            state_in  = ST_TICK_LOAD;
         end
         ST_TICK_LOAD: begin
            dp_cmd.op = OP_TICK_LOAD;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               dp_cmd.op = OP_CAPTURE;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_SINGLE_ON;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ src/lbp_dp.sv @@
// ----------------------------------------------------------------------------
// LED blink pattern player datapath
// Pattern memory, table length, step index, countdown, interjection state,
// LED level and the output register, updated by controller commands.
// ----------------------------------------------------------------------------
module lbp_dp import lbp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic [DUR_FIELD_BITS-1:0] req_duration,
   input  logic [CNT_BITS-1:0]       req_count,
   input  dp_cmd_type                dp_cmd,
   output dp_status_type             status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_led_level,
   output logic                      rsp_interjection_active,
   output logic [PLEN_BITS-1:0]      rsp_pattern_length,
   output logic                      rsp_overflow
);

   logic [DURATION_BITS-1:0] pattern_mem [PATTERN_DEPTH];

   logic [LEN_BITS-1:0]       len_ff, len_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   logic [CD_BITS-1:0]        cd_ff, cd_in;
   logic [CNT_BITS-1:0]       once_count_ff, once_count_in;
   logic                      led_ff, led_in;
   logic                      dropped_ff, dropped_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [DUR_FIELD_BITS-1:0] dur_ff, dur_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [DUR_FIELD_BITS-1:0] once_size_ff, once_size_in;
   logic [DIGIT_BITS-1:0]     digit_n_ff, digit_n_in;
   logic [DIGIT_BITS-1:0]     digit_i_ff, digit_i_in;
   logic                      once_mode_ff, once_mode_in;
   logic                      adv_ff, adv_in;
   logic [DIV_BITS-1:0]       div_ff, div_in;
   logic [STEP_BITS-1:0]      wrap_len_ff, wrap_len_in;
   logic [WIDE_BITS-1:0]      once_entry_ff, once_entry_in;
   logic [DURATION_BITS-1:0]  rd_ff;
   logic                      rsp_led_ff, rsp_led_in;
   logic                      rsp_once_ff, rsp_once_in;
   logic [PLEN_BITS-1:0]      rsp_len_ff, rsp_len_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic                      once_live;
   logic                      len_nz;
   logic                      full;
   logic [LEN_BITS-1:0]       len_m1;
   logic [DUR_FIELD_BITS-1:0] app_val;
   logic                      merge;
   logic                      push;
   logic [WIDE_BITS-1:0]      sum;
   logic [DIV_BITS-1:0]       div_raw;
   logic [DIV_BITS-1:0]       div_eff;
   logic [STEP_BITS-1:0]      once_len;
   logic [STEP_BITS-1:0]      once_last;
   logic [WIDE_BITS-1:0]      entry_sel;
   logic [CD_BITS-1:0]        prod;
   logic                      mem_we;
   logic [ADDR_BITS-1:0]      mem_waddr;
   logic [DURATION_BITS-1:0]  mem_wdata;
   logic                      mem_re;
   logic [ADDR_BITS-1:0]      mem_raddr;

   assign once_live = (once_count_ff != '0);
   assign len_nz    = (len_ff != '0);
   assign full      = (len_ff >= LEN_BITS'(PATTERN_DEPTH));
   assign len_m1    = len_ff - LEN_BITS'(1);
   assign merge     = dp_cmd.app_on ? len_ff[0] : (!len_ff[0] && len_nz);
   assign push      = dp_cmd.app_on ? !len_ff[0] : len_ff[0];
   assign sum       = WIDE_BITS'(rd_ff) + WIDE_BITS'(app_val);
   assign div_raw   = once_live ? div_by_five(cfg.tick_divider) : cfg.tick_divider;
   assign div_eff   = (div_raw == '0) ? DIV_BITS'(1) : div_raw;
   assign once_len  = STEP_BITS'({once_count_ff, 1'b0});
   assign once_last = once_len - STEP_BITS'(1);
   assign entry_sel = once_mode_ff ? once_entry_ff : WIDE_BITS'(rd_ff);
   assign prod      = entry_sel * div_ff;

   always_comb begin
      unique case (dp_cmd.app_val)
         VAL_DURATION: app_val = dur_ff;
         VAL_DIGIT_ON: app_val = (digit_i_ff == '0) ? DIGIT_FIRST_ON : DIGIT_UNIT;
         VAL_UNIT:     app_val = DIGIT_UNIT;
         VAL_TAIL:     app_val = DIGIT_TAIL_OFF;
         default:      app_val = dur_ff;
      endcase
   end

   assign status.tick_active = cfg.led_enable && (once_live || len_nz);
   assign status.cd_zero     = (cd_ff == '0);
   assign status.cd_one      = (cd_ff == CD_BITS'(1));
   assign status.wrap_done   = (step_ff < wrap_len_ff);
   assign status.digit_last  = (digit_i_ff == digit_n_ff - DIGIT_BITS'(1));
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = len_ff[ADDR_BITS-1:0];
      mem_wdata = clamp_duration(WIDE_BITS'(app_val));
      mem_re    = 1'b0;
      mem_raddr = len_m1[ADDR_BITS-1:0];
      if (dp_cmd.op == OP_APP_WRITE) begin
         if (merge) begin
            mem_we    = 1'b1;
            mem_waddr = len_m1[ADDR_BITS-1:0];
            mem_wdata = clamp_duration(sum);
         end else if (push && !full) begin
            mem_we = 1'b1;
         end
      end
      if (dp_cmd.op == OP_APP_READ) begin
         mem_re = 1'b1;
      end else if (dp_cmd.op == OP_TICK_READ) begin
         mem_re    = 1'b1;
         mem_raddr = step_ff[ADDR_BITS-1:0];
      end
   end

   always_comb begin
      len_in        = len_ff;
      step_in       = step_ff;
      cd_in         = cd_ff;
      once_count_in = once_count_ff;
      led_in        = led_ff;
      dropped_in    = dropped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      dur_in        = dur_ff;
      cnt_in        = cnt_ff;
      once_size_in  = once_size_ff;
      digit_n_in    = digit_n_ff;
      digit_i_in    = digit_i_ff;
      once_mode_in  = once_mode_ff;
      adv_in        = adv_ff;
      div_in        = div_ff;
      wrap_len_in   = wrap_len_ff;
      once_entry_in = once_entry_ff;
      rsp_led_in    = rsp_led_ff;
      rsp_once_in   = rsp_once_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (dp_cmd.accept) begin
         dur_in     = req_duration;
         cnt_in     = req_count;
         digit_n_in = digit_blinks(req_count);
         digit_i_in = '0;
         dropped_in = 1'b0;
      end

      unique case (dp_cmd.op)
         OP_NONE: ;
         OP_CLEAR: len_in = '0;
         OP_INTERJECT: begin
            once_count_in = cnt_ff;
            once_size_in  = dur_ff;
            step_in       = '0;
            cd_in         = '0;
         end
         OP_APP_READ: ;
         OP_APP_WRITE: begin
            if (!merge && push) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  len_in = len_ff + LEN_BITS'(1);
               end
            end
            if (dp_cmd.digit_next) begin
               digit_i_in = digit_i_ff + DIGIT_BITS'(1);
            end
         end
         OP_TICK_CHECK: begin
            once_mode_in = once_live;
            div_in       = div_eff;
            wrap_len_in  = once_live ? once_len : STEP_BITS'(len_ff);
            adv_in       = 1'b0;
            if (status.tick_active) begin
               if (status.cd_zero) begin
                  step_in = '0;
               end else begin
                  cd_in = cd_ff - CD_BITS'(1);
                  if (status.cd_one) begin
                     step_in = step_ff + STEP_BITS'(1);
                     adv_in  = 1'b1;
                  end
               end
            end
         end
         OP_TICK_WRAP: begin
            if (!status.wrap_done) begin
               step_in = step_ff - wrap_len_ff;
            end
         end
         OP_TICK_READ: begin
            once_entry_in = WIDE_BITS'(once_size_ff)
                          + ((step_ff == once_last) ? INTERJECT_TAIL : '0);
         end
         OP_TICK_LOAD: begin
            cd_in  = prod;
            led_in = !step_ff[0];
            if (once_mode_ff && adv_ff && (step_ff == '0)) begin
               once_count_in = '0;
               cd_in         = '0;
               step_in       = '0;
            end
         end
         OP_CAPTURE: begin
            rsp_valid_in = 1'b1;
            rsp_led_in   = led_ff ^ cfg.invert_level;
            rsp_once_in  = once_live;
            rsp_len_in   = PLEN_BITS'(len_ff);
            rsp_ovf_in   = dropped_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pattern_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= pattern_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         step_ff       <= '0;
         cd_ff         <= '0;
         once_count_ff <= '0;
         led_ff        <= 1'b0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         step_ff       <= step_in;
         cd_ff         <= cd_in;
         once_count_ff <= once_count_in;
         led_ff        <= led_in;
         dropped_ff    <= dropped_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff        <= dur_in;
      cnt_ff        <= cnt_in;
      once_size_ff  <= once_size_in;
      digit_n_ff    <= digit_n_in;
      digit_i_ff    <= digit_i_in;
      once_mode_ff  <= once_mode_in;
      adv_ff        <= adv_in;
      div_ff        <= div_in;
      wrap_len_ff   <= wrap_len_in;
      once_entry_ff <= once_entry_in;
      rsp_led_ff    <= rsp_led_in;
      rsp_once_ff   <= rsp_once_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_led_level           = rsp_led_ff;
   assign rsp_interjection_active = rsp_once_ff;
   assign rsp_pattern_length      = rsp_len_ff;
   assign rsp_overflow            = rsp_ovf_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_BITS'(PATTERN_DEPTH))
      else $error("pattern table length beyond its depth");

   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_CAPTURE) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a word not yet taken");

   a_read_in_table: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_TICK_READ && !once_mode_ff) |-> (step_ff < STEP_BITS'(len_ff)))
      else $error("tick read outside the written table");

   a_interject_end: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_TICK_LOAD && once_mode_ff && adv_ff && step_ff == '0)
      |=> (once_count_ff == '0 && cd_ff == '0))
      else $error("interjection did not end on wrap");

endmodule

@@ src/led_blink_pattern_player_top.sv @@
// ----------------------------------------------------------------------------
// LED blink pattern player
// Each command word returns one status word. Add on and add off do a table
// read and a write of the pattern memory; clear and interject need no memory
// access. Add digit performs 2n+1 appends. When the index steps normally a
// tick runs countdown check, index wrap, memory read, then the
// duration-times-divider multiply. The wrap subtracts the table or interjection
// length once per cycle, so after a clear that shortened the table it repeats
// until the index is below that length. A finished status word waits in the
// output register while the next command is taken.
// ----------------------------------------------------------------------------
module led_blink_pattern_player_top import lbp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [23:0]              req_tdata,  // duration[15:0], count[23:16]
   input  logic [CMD_BITS-1:0]      req_tuser,  // cmd[2:0]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // led_level[0], interjection_active[1], pattern_length[8:2], overflow[9]
   output logic [15:0]              rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type              cfg;
   dp_cmd_type           dp_cmd;
   dp_status_type        status;
   logic                 led_level;
   logic                 interjection_active;
   logic [PLEN_BITS-1:0] pattern_length;
   logic                 overflow;

   lbp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (cmd_type'(req_tuser)),
      .req_tready (req_tready),
      .status     (status),
      .dp_cmd     (dp_cmd)
   );

   lbp_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cfg                     (cfg),
      .req_duration            (req_tdata[15:0]),
      .req_count               (req_tdata[23:16]),
      .dp_cmd                  (dp_cmd),
      .status                  (status),
      .rsp_ready               (rsp_tready),
      .rsp_valid               (rsp_tvalid),
      .rsp_led_level           (led_level),
      .rsp_interjection_active (interjection_active),
      .rsp_pattern_length      (pattern_length),
      .rsp_overflow            (overflow)
   );

   assign rsp_tdata = {6'b0, overflow, pattern_length, interjection_active, led_level};

endmodule
